[rtl/core/gccw_pkg.sv]
// ----------------------------------------------------------------------------
// gccw_pkg
// Shared types and constants of the grid cell cover walker.
// ----------------------------------------------------------------------------
package gccw_pkg;

  localparam int unsigned MaxCells      = 64;
  localparam int unsigned CellIndexBits = 16;
  localparam int unsigned Slack         = 2;
  localparam int unsigned CntW          = $clog2(MaxCells + 1);
  localparam logic [30:0] DefaultCell   = 31'd65536;
  localparam logic [47:0] TInf          = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] TFinMax       = 48'hFFFF_FFFF_FFFE;

  typedef enum logic {
    REQ_BOX = 1'b0,
    REQ_SEG = 1'b1
  } req_type_e;

  typedef struct packed {
    logic        req_type;
    logic [15:0] item_id;
    logic [31:0] x_a;
    logic [31:0] y_a;
    logic [31:0] x_b;
    logic [31:0] y_b;
  } req_t;

  typedef struct packed {
    logic [15:0] out_item_id;
    logic [15:0] cell_x;
    logic [15:0] cell_y;
    logic        last;
    logic        truncated;
  } res_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic        is_seg;
    logic [15:0] item_id;
    logic [33:0] cx0;    // box: x lo, seg: start x
    logic [33:0] cy0;
    logic [33:0] cx1;    // box: x hi, seg: end x
    logic [33:0] cy1;
    logic [47:0] tnx;
    logic [47:0] tny;
    logic [47:0] tsx;
    logic [47:0] tsy;
    logic        sx_pos;
    logic        sy_pos;
    logic [35:0] span;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_TDIV,
    F_PUSH
  } front_state_e;

  function automatic logic [15:0] sat_cell(input logic [33:0] c);
    logic signed [33:0] s;
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    s  = c;
    hi = 34'sd1 <<< (CellIndexBits - 1);
    hi = hi - 34'sd1;
    lo = -hi - 34'sd1;
    if (s > hi) return hi[15:0];
    if (s < lo) return lo[15:0];
    return s[15:0];
  endfunction

endpackage

[rtl/core/gccw_req_if.sv]
// ----------------------------------------------------------------------------
// gccw_req_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface gccw_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] item_id;
  logic [31:0] x_a;
  logic [31:0] y_a;
  logic [31:0] x_b;
  logic [31:0] y_b;
  modport source (output valid, req_type, item_id, x_a, y_a, x_b, y_b, input ready);
  modport sink   (input valid, req_type, item_id, x_a, y_a, x_b, y_b, output ready);
endinterface

interface gccw_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_item_id;
  logic [15:0] cell_x;
  logic [15:0] cell_y;
  logic        last;
  logic        truncated;
  modport source (output valid, out_item_id, cell_x, cell_y, last, truncated, input ready);
  modport sink   (input valid, out_item_id, cell_x, cell_y, last, truncated, output ready);
endinterface

interface gccw_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] cell_size;
  modport source (output valid, cell_size, input ready);
  modport sink   (input valid, cell_size, output ready);
endinterface

[rtl/core/grid_cell_cover_walker.sv]
// ----------------------------------------------------------------------------
// grid_cell_cover_walker
// Lists the grid cells covered by a box or crossed by a segment.
// ----------------------------------------------------------------------------
// Each division in the front runs in one shared bit-serial divider, which
// takes a start step and then forms 80 quotient bits. A box needs the
// accept step, four floor divisions and a hand-off step. A segment adds
// four parameter divisions, each cut short on an axis with zero delta.
// The back then loads the job and emits one cell per cycle while the
// receiver is ready; front and back overlap through a two-entry queue.
// Cells come out one per transfer, last marks the final cell and
// truncated marks a run cut at 64 cells.
module grid_cell_cover_walker (
  input  logic      clk_i,
  input  logic      rst_ni,
  gccw_req_if.sink  req,
  gccw_cfg_if.sink  cfg,
  gccw_res_if.source res
);
  import gccw_pkg::*;

  logic [30:0] cell_size_q;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cell_size_q <= DefaultCell;
    else if (cfg.valid) cell_size_q <= cfg.cell_size;
  end

  gccw_front u_front (
    .clk_i, .rst_ni, .req, .cell_size_i(cell_size_q),
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  gccw_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(fj_valid), .in_ready_o(fj_ready), .in_job_i(fj),
    .out_valid_o(bj_valid), .out_ready_i(bj_ready), .out_job_o(bj)
  );

  gccw_back u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj), .res
  );
endmodule

[rtl/core/gccw_divider.sv]
// ----------------------------------------------------------------------------
// gccw_divider
// Radix-2 restoring divider, one quotient bit per cycle, 80/48 unsigned.
// ----------------------------------------------------------------------------
module gccw_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [79:0] num_i,
  input  logic [47:0] den_i,
  output logic        done_o,
  output logic [79:0] quot_o,
  output logic [47:0] rem_o
);
  logic [79:0] q_q, q_d;
  logic [48:0] r_q, r_d;
  logic [47:0] den_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [48:0] trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {r_q[47:0], q_q[79]} - {1'b0, den_q};
    if (start_i) begin
      q_d    = num_i;
      r_d    = '0;
      cnt_d  = 7'd80;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[48]) begin
        r_d = trial;
        q_d = {q_q[78:0], 1'b1};
      end else begin
        r_d = {r_q[47:0], q_q[79]};
        q_d = {q_q[78:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == 7'd1);
  assign quot_o = !trial[48] ? {q_q[78:0], 1'b1} : {q_q[78:0], 1'b0};
  assign rem_o  = !trial[48] ? trial[47:0] : {r_q[46:0], q_q[79]};
endmodule

[rtl/core/gccw_front.sv]
// ----------------------------------------------------------------------------
// gccw_front
// Accepts requests, floors coordinates and sets up walk parameters.
// ----------------------------------------------------------------------------
module gccw_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  gccw_req_if.sink       req,
  input  logic [30:0]    cell_size_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output gccw_pkg::job_t job_o
);
  import gccw_pkg::*;

  front_state_e st_q, st_d;
  req_t         r_q;
  job_t         j_q;
  logic [2:0]   idx_q, idx_d;
  logic [47:0]  cs;
  logic         dv_done;
  logic [79:0]  dv_num, dv_quot;
  logic [47:0]  dv_den, dv_rem;
  logic signed [32:0] dx, dy;
  logic [32:0]  adx, ady;
  logic signed [31:0] pick;
  logic [31:0]  mag;
  logic signed [33:0] fl;
  logic signed [33:0] cell_c;
  logic signed [65:0] bnd_dist;
  logic [47:0]  tq;

  assign cs = {17'd0, (cell_size_i == 31'd0) ? DefaultCell : cell_size_i};
  assign dx = $signed({r_q.x_b[31], r_q.x_b}) - $signed({r_q.x_a[31], r_q.x_a});
  assign dy = $signed({r_q.y_b[31], r_q.y_b}) - $signed({r_q.y_a[31], r_q.y_a});
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);

  // Floor-division operand for idx 0..3.
  always_comb begin
    unique case (idx_q[1:0])
      2'd0: pick = (r_q.req_type == REQ_BOX && $signed(r_q.x_b) < $signed(r_q.x_a))
                   ? r_q.x_b : r_q.x_a;
      2'd1: pick = (r_q.req_type == REQ_BOX && $signed(r_q.y_b) < $signed(r_q.y_a))
                   ? r_q.y_b : r_q.y_a;
      2'd2: pick = (r_q.req_type == REQ_BOX && $signed(r_q.x_b) < $signed(r_q.x_a))
                   ? r_q.x_a : r_q.x_b;
      default: pick = (r_q.req_type == REQ_BOX && $signed(r_q.y_b) < $signed(r_q.y_a))
                   ? r_q.y_a : r_q.y_b;
    endcase
    mag = pick[31] ? 32'(-pick) : 32'(pick);
  end

  // Distance to first boundary, idx 4 = x, 5 = y (after t step idx 6/7 order).
  always_comb begin
    logic signed [33:0] p;
    logic                pos;
    if (idx_q[0] == 1'b0) begin
      p = 34'(signed'(r_q.x_a)); pos = !dx[32] && dx != 0; cell_c = j_q.cx0;
    end else begin
      p = 34'(signed'(r_q.y_a)); pos = !dy[32] && dy != 0; cell_c = j_q.cy0;
    end
    if (pos) bnd_dist = 66'((cell_c + 34'sd1) * $signed({1'b0, cs[30:0]})) - 66'(p);
    else     bnd_dist = 66'(p) - 66'(cell_c * $signed({1'b0, cs[30:0]}));
    if (bnd_dist < 0) bnd_dist = '0;
  end

  always_comb begin
    dv_num   = '0;
    dv_den   = cs;
    if (st_q == F_DIV && idx_q[2] == 1'b0) begin
      dv_num = {48'd0, mag};
    end else if (idx_q[1] == 1'b0) begin
      dv_num = {bnd_dist[47:0], 32'd0};
      dv_den = {15'd0, idx_q[0] ? ady : adx};
    end else begin
      dv_num = {cs, 32'd0};
      dv_den = {15'd0, idx_q[0] ? ady : adx};
    end
  end

  logic launch_q, launch_d;
  assign tq = (dv_quot > {32'd0, TFinMax}) ? TFinMax : dv_quot[47:0];
  assign fl = pick[31] ? ((dv_rem != 0) ? -$signed({2'b0, dv_quot[31:0]}) - 34'sd1
                                        : -$signed({2'b0, dv_quot[31:0]}))
                       : $signed({2'b0, dv_quot[31:0]});

  gccw_divider u_div (
    .clk_i, .rst_ni, .start_i(launch_q), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quot_o(dv_quot), .rem_o(dv_rem)
  );

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    launch_d = 1'b0;
    unique case (st_q)
      F_IDLE: if (req.valid) begin
        st_d = F_DIV; idx_d = '0; launch_d = 1'b1;
      end
      F_DIV: if (dv_done) begin
        if (idx_q == 3'd3) begin
          if (r_q.req_type == REQ_BOX) st_d = F_PUSH;
          else begin st_d = F_TDIV; idx_d = 3'd4; launch_d = 1'b1; end
        end else begin
          idx_d = idx_q + 3'd1; launch_d = 1'b1;
        end
      end
      F_TDIV: if (dv_done || ((idx_q[0] ? ady : adx) == 0 && !launch_q)) begin
        if (idx_q == 3'd7) st_d = F_PUSH;
        else begin idx_d = idx_q + 3'd1; launch_d = 1'b1; end
      end
      F_PUSH: if (job_ready_i) st_d = F_IDLE;
      default: st_d = F_IDLE;
    endcase
  end

  assign req.ready   = (st_q == F_IDLE);
  assign job_valid_o = (st_q == F_PUSH);
  assign job_o       = j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= F_IDLE;
      idx_q    <= '0;
      launch_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && req.valid) begin
      r_q.req_type <= req.req_type;
      r_q.item_id  <= req.item_id;
      r_q.x_a      <= req.x_a;
      r_q.y_a      <= req.y_a;
      r_q.x_b      <= req.x_b;
      r_q.y_b      <= req.y_b;
    end
    if (st_q == F_DIV && dv_done) begin
      unique case (idx_q[1:0])
        2'd0: j_q.cx0 <= fl;
        2'd1: j_q.cy0 <= fl;
        2'd2: j_q.cx1 <= fl;
        default: j_q.cy1 <= fl;
      endcase
      if (idx_q == 3'd3) begin
        j_q.is_seg  <= r_q.req_type;
        j_q.item_id <= r_q.item_id;
        j_q.sx_pos  <= !dx[32] && dx != 0;
        j_q.sy_pos  <= !dy[32] && dy != 0;
        j_q.tnx <= TInf; j_q.tny <= TInf; j_q.tsx <= TInf; j_q.tsy <= TInf;
      end
    end
    if (st_q == F_TDIV && dv_done) begin
      unique case (idx_q[1:0])
        2'd0: j_q.tnx <= tq;
        2'd1: j_q.tny <= tq;
        2'd2: j_q.tsx <= tq;
        default: j_q.tsy <= tq;
      endcase
    end
    if (st_q == F_TDIV && idx_q == 3'd4 && launch_q) begin
      j_q.span <= 36'(($signed(j_q.cx1) > $signed(j_q.cx0) ? j_q.cx1 - j_q.cx0
                                                           : j_q.cx0 - j_q.cx1))
                + 36'(($signed(j_q.cy1) > $signed(j_q.cy0) ? j_q.cy1 - j_q.cy0
                                                           : j_q.cy0 - j_q.cy1))
                + 36'(Slack);
    end
  end
endmodule

[rtl/core/gccw_queue.sv]
// ----------------------------------------------------------------------------
// gccw_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module gccw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gccw_pkg::job_t in_job_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gccw_pkg::job_t out_job_o
);
  import gccw_pkg::*;
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_job_o   = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_job_i;
  end
endmodule

[rtl/core/gccw_back.sv]
// ----------------------------------------------------------------------------
// gccw_back
// Emits cells of a job: box raster or segment walk, one cell per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module gccw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  gccw_pkg::job_t job_i,
  gccw_res_if.source     res
);
  import gccw_pkg::*;

  logic        busy_q;
  job_t        j_q;
  logic [33:0] cx_q, cy_q;
  logic [47:0] tnx_q, tny_q;
  logic [35:0] step_q;
  logic [CntW-1:0] cnt_q;
  logic        ov_q;
  res_t        o_q;
  logic        adv, fin, full, wend;
  logic [33:0] bx0, by0, bx1, by1;
  logic [33:0] nx, ny;

  assign bx0 = {{18{1'b0}}, 16'd0} | 34'(signed'(sat_cell(j_q.cx0)));
  assign by0 = 34'(signed'(sat_cell(j_q.cy0)));
  assign bx1 = 34'(signed'(sat_cell(j_q.cx1)));
  assign by1 = 34'(signed'(sat_cell(j_q.cy1)));

  assign adv = busy_q && (!ov_q || res.ready);
  assign full = (cnt_q == CntW'(MaxCells - 1));

  always_comb begin
    nx   = cx_q;
    ny   = cy_q;
    if (!j_q.is_seg) begin
      wend = (cx_q == bx1) && (cy_q == by1);
      if (cx_q == bx1) begin nx = bx0; ny = cy_q + 34'd1; end
      else nx = cx_q + 34'd1;
    end else begin
      wend = ((cx_q == j_q.cx1) && (cy_q == j_q.cy1)) || (step_q == j_q.span);
      if (tnx_q < tny_q) nx = j_q.sx_pos ? cx_q + 34'd1 : cx_q - 34'd1;
      else               ny = j_q.sy_pos ? cy_q + 34'd1 : cy_q - 34'd1;
    end
  end

  // Box with inverted corners cannot happen after normalisation.
  assign fin = wend || full;
  assign job_ready_o = !busy_q;

  logic [47:0] ta, tb, tn;
  assign ta  = (tnx_q < tny_q) ? tnx_q : tny_q;
  assign tb  = (tnx_q < tny_q) ? j_q.tsx : j_q.tsy;
  assign tn  = (ta == TInf || tb == TInf) ? TInf
             : ((49'(ta) + 49'(tb)) > 49'(TFinMax) ? TFinMax : 48'(ta + tb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (ov_q && res.ready && !adv) ov_q <= 1'b0;
      if (!busy_q && job_valid_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (adv) begin
        ov_q  <= 1'b1;
        cnt_q <= cnt_q + CntW'(1);
        if (fin) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && job_valid_i) begin
      j_q    <= job_i;
      cx_q   <= job_i.is_seg ? job_i.cx0 : 34'(signed'(sat_cell(job_i.cx0)));
      cy_q   <= job_i.is_seg ? job_i.cy0 : 34'(signed'(sat_cell(job_i.cy0)));
      tnx_q  <= job_i.tnx;
      tny_q  <= job_i.tny;
      step_q <= '0;
    end else if (adv) begin
      o_q.out_item_id <= j_q.item_id;
      o_q.cell_x      <= sat_cell(cx_q);
      o_q.cell_y      <= sat_cell(cy_q);
      o_q.last        <= fin;
      o_q.truncated   <= full && !wend;
      cx_q   <= nx;
      cy_q   <= ny;
      step_q <= step_q + 36'd1;
      if (j_q.is_seg) begin
        if (tnx_q < tny_q) tnx_q <= tn;
        else               tny_q <= tn;
      end
    end
  end

  assign res.valid       = ov_q;
  assign res.out_item_id = o_q.out_item_id;
  assign res.cell_x      = o_q.cell_x;
  assign res.cell_y      = o_q.cell_y;
  assign res.last        = o_q.last;
  assign res.truncated   = o_q.truncated;
endmodule

[verif/gccw_cover_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gccw_cover_checker
// Watches the request, configuration and result channels of the grid cell
// cover walker, predicts the cell list of every accepted request and compares
// each result transfer field by field with the oldest predicted cell.
// ----------------------------------------------------------------------------
module gccw_cover_checker
  import gccw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gccw_req_if  req,
  gccw_cfg_if  cfg,
  gccw_res_if  res,
  output int   mismatch_cnt_o,
  output int   cells_pending_o
);

  logic [30:0] cell_edge;
  res_t        cells_due[$];
  int unsigned run_len;
  bit          run_cut;

  function automatic longint floor_q(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_idx(longint c);
    if (c > 32767) return 32767;
    if (c < -32768) return -32768;
    return c;
  endfunction

  function automatic longint unsigned t_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num << 32) / den;
    return (q > longint'(TFinMax)) ? longint'(TFinMax) : q;
  endfunction

  function automatic longint unsigned t_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    if (a == longint'(TInf) || b == longint'(TInf)) return longint'(TInf);
    s = a + b;
    return (s > longint'(TFinMax)) ? longint'(TFinMax) : s;
  endfunction

  function automatic bit add_cell(logic [15:0] id, longint cx, longint cy);
    res_t   c;
    longint sx;
    longint sy;
    if (run_len >= MaxCells) begin
      run_cut = 1'b1;
      return 1'b0;
    end
    sx            = clamp_idx(cx);
    sy            = clamp_idx(cy);
    c.out_item_id = id;
    c.cell_x      = sx[15:0];
    c.cell_y      = sy[15:0];
    c.last        = 1'b0;
    c.truncated   = 1'b0;
    cells_due.push_back(c);
    run_len++;
    return 1'b1;
  endfunction

  function automatic void axis_times(longint p, longint d, longint c, longint cs,
                                     output longint unsigned tn,
                                     output longint unsigned ts);
    longint unsigned ad;
    longint          bnd_dist;
    if (d == 0) begin
      tn = longint'(TInf);
      ts = longint'(TInf);
      return;
    end
    ad       = (d > 0) ? d : -d;
    bnd_dist = (d > 0) ? (c + 1) * cs - p : p - c * cs;
    if (bnd_dist < 0) bnd_dist = 0;
    tn = t_quot(bnd_dist, ad);
    ts = t_quot(cs, ad);
  endfunction

  function automatic void predict_cells(req_t r);
    longint          xa, ya, xb, yb, cs;
    longint          x0, x1, y0, y1, cx, cy, ex, ey, dx, dy, stx, sty, span, ax, ay;
    longint unsigned tnx, tny, tsx, tsy;
    bit              go;
    int              n;
    xa      = longint'(signed'(r.x_a));
    ya      = longint'(signed'(r.y_a));
    xb      = longint'(signed'(r.x_b));
    yb      = longint'(signed'(r.y_b));
    cs      = (cell_edge == 0) ? longint'(DefaultCell) : longint'(cell_edge);
    run_len = 0;
    run_cut = 1'b0;
    if (req_type_e'(r.req_type) == REQ_BOX) begin
      x0 = clamp_idx(floor_q((xa < xb) ? xa : xb, cs));
      x1 = clamp_idx(floor_q((xa < xb) ? xb : xa, cs));
      y0 = clamp_idx(floor_q((ya < yb) ? ya : yb, cs));
      y1 = clamp_idx(floor_q((ya < yb) ? yb : ya, cs));
      go = 1'b1;
      for (cy = y0; go && cy <= y1; cy++)
        for (cx = x0; go && cx <= x1; cx++)
          go = add_cell(r.item_id, cx, cy);
    end else begin
      ex  = floor_q(xb, cs);
      ey  = floor_q(yb, cs);
      dx  = xb - xa;
      dy  = yb - ya;
      stx = (dx > 0) ? 1 : -1;
      sty = (dy > 0) ? 1 : -1;
      cx  = floor_q(xa, cs);
      cy  = floor_q(ya, cs);
      axis_times(xa, dx, cx, cs, tnx, tsx);
      axis_times(ya, dy, cy, cs, tny, tsy);
      ax   = ex - cx;
      ay   = ey - cy;
      span = ((ax < 0) ? -ax : ax) + ((ay < 0) ? -ay : ay) + Slack;
      for (longint s = 0; s <= span; s++) begin
        if (!add_cell(r.item_id, cx, cy)) break;
        if (cx == ex && cy == ey) break;
        if (tnx < tny) begin
          cx  = cx + stx;
          tnx = t_sum(tnx, tsx);
        end else begin
          cy  = cy + sty;
          tny = t_sum(tny, tsy);
        end
      end
    end
    n = cells_due.size() - 1;
    cells_due[n].last      = 1'b1;
    cells_due[n].truncated = run_cut;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_edge      = DefaultCell;
      mismatch_cnt_o = 0;
      cells_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) cell_edge = cfg.cell_size;
      if (req.valid && req.ready) begin
        req_t r;
        r = '{req.req_type, req.item_id, req.x_a, req.y_a, req.x_b, req.y_b};
        predict_cells(r);
      end
      if (res.valid && res.ready) begin
        res_t got;
        res_t want;
        got = '{res.out_item_id, res.cell_x, res.cell_y, res.last, res.truncated};
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell transfer %p", $time, got);
          mismatch_cnt_o++;
        end else begin
          want = cells_due.pop_front();
          if (got.out_item_id !== want.out_item_id) begin
            $display("%0t: item_id exp %h got %h", $time, want.out_item_id, got.out_item_id);
            mismatch_cnt_o++;
          end
          if (got.cell_x !== want.cell_x) begin
            $display("%0t: cell_x exp %h got %h", $time, want.cell_x, got.cell_x);
            mismatch_cnt_o++;
          end
          if (got.cell_y !== want.cell_y) begin
            $display("%0t: cell_y exp %h got %h", $time, want.cell_y, got.cell_y);
            mismatch_cnt_o++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last exp %b got %b", $time, want.last, got.last);
            mismatch_cnt_o++;
          end
          if (got.truncated !== want.truncated) begin
            $display("%0t: truncated exp %b got %b", $time, want.truncated, got.truncated);
            mismatch_cnt_o++;
          end
        end
      end
    end
    cells_pending_o = cells_due.size();
  end

endmodule

[verif/tb_grid_cell_cover_walker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_cell_cover_walker
// Drives boxes and segments through the walker under several cell sizes,
// with bursty requests, a stalling receiver and one long hold-off; the
// checker beside the block predicts and compares every cell.
// ----------------------------------------------------------------------------
module tb_grid_cell_cover_walker;
  import gccw_pkg::*;

  localparam int HoldCycles = 3000;
  localparam int IdleLimit  = 40000;

  logic        clk_i;
  logic        rst_ni;
  int          mismatches;
  int          cells_pending;
  int          items_sent;
  int          burst_left;
  int          idle_cycles;
  logic [30:0] cur_edge;

  gccw_req_if req_ch ();
  gccw_cfg_if cfg_ch ();
  gccw_res_if res_ch ();

  grid_cell_cover_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .cfg    (cfg_ch),
    .res    (res_ch)
  );

  gccw_cover_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req             (req_ch),
    .cfg             (cfg_ch),
    .res             (res_ch),
    .mismatch_cnt_o  (mismatches),
    .cells_pending_o (cells_pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (req_ch.valid && req_ch.ready || res_ch.valid && res_ch.ready ||
        cfg_ch.valid && cfg_ch.ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: own stall pattern, one long hold-off once traffic is under way
  initial begin
    int  mode;
    int  left;
    bit  held;
    res_ch.ready = 1'b0;
    held         = 1'b0;
    left         = 0;
    mode         = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && items_sent >= 60) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= $urandom_range(0, 1);
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_req(req_type_e kind, logic [15:0] id, logic [31:0] xa,
                          logic [31:0] ya, logic [31:0] xb, logic [31:0] yb);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.item_id  <= id;
    req_ch.x_a      <= xa;
    req_ch.y_a      <= ya;
    req_ch.x_b      <= xb;
    req_ch.y_b      <= yb;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_cells();
    req_ch.valid <= 1'b0;
    do @(negedge clk_i); while (cells_pending != 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_edge(logic [30:0] v);
    drain_cells();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.cell_size <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_edge = v;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    longint w;
    longint off;
    w   = 6 * ((cur_edge == 0) ? longint'(DefaultCell) : longint'(cur_edge));
    off = (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF) % (2 * w + 1) - w;
    return base + off[31:0];
  endfunction

  task automatic random_items(int n);
    logic [31:0] b;
    repeat (n) begin
      b = $urandom;
      if ($urandom_range(0, 3) == 0)
        send_req(req_type_e'($urandom_range(0, 1)), 16'($urandom), $urandom, $urandom,
                 $urandom, $urandom);
      else
        send_req(req_type_e'($urandom_range(0, 1)), 16'($urandom), near(b), near(b),
                 near(b), near(b));
    end
  endtask

  initial begin
    logic [30:0] edges[4];
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_BOX;
    req_ch.item_id   = '0;
    req_ch.x_a       = '0;
    req_ch.y_a       = '0;
    req_ch.x_b       = '0;
    req_ch.y_b       = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.cell_size = DefaultCell;
    cur_edge         = DefaultCell;
    items_sent       = 0;
    burst_left       = 0;
    idle_cycles      = 0;
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, default 1.0 cells
    send_req(REQ_BOX, 16'h0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_req(REQ_BOX, 16'hFFFF, 32'h0003_0000, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFE_8000);
    send_req(REQ_BOX, 16'h1001, 32'h0000_0000, 32'h0000_0000, 32'h0007_FFFF, 32'h0007_FFFF);
    send_req(REQ_BOX, 16'h1002, 32'h0000_0000, 32'h0000_0000, 32'h0008_0000, 32'h0007_0000);
    send_req(REQ_BOX, 16'h1003, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_req(REQ_SEG, 16'h2001, 32'h0000_8000, 32'h0000_8000, 32'h0005_8000, 32'h0000_8000);
    send_req(REQ_SEG, 16'h2002, 32'h0000_8000, 32'h0004_8000, 32'h0000_8000, 32'hFFFE_8000);
    send_req(REQ_SEG, 16'h2003, 32'h0001_4000, 32'h0001_4000, 32'h0001_4000, 32'h0001_4000);
    send_req(REQ_SEG, 16'h2004, 32'h0000_8000, 32'h0000_8000, 32'h0003_8000, 32'h0003_8000);
    send_req(REQ_SEG, 16'h2005, 32'h0003_0000, 32'h0002_0000, 32'hFFFD_0000, 32'hFFFF_0000);
    send_req(REQ_SEG, 16'h2006, 32'h0000_0000, 32'h0000_0000, 32'h0050_0000, 32'h0013_0000);
    send_req(REQ_SEG, 16'h2007, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(REQ_SEG, 16'h2008, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_8000);
    random_items(24);

    edges = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'h0003_8000};
    foreach (edges[i]) begin
      set_edge(edges[i]);
      send_req(REQ_BOX, 16'h3000, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_req(REQ_SEG, 16'h3001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0002);
      random_items(32);
    end
    set_edge(DefaultCell);
    random_items(12);

    drain_cells();
    if (mismatches == 0 && cells_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/gccw_pkg.sv
rtl/core/gccw_req_if.sv
rtl/core/gccw_divider.sv
rtl/core/gccw_front.sv
rtl/core/gccw_queue.sv
rtl/core/gccw_back.sv
rtl/core/grid_cell_cover_walker.sv
verif/gccw_cover_checker.sv
verif/tb_grid_cell_cover_walker.sv
